// ===== rtl/nvcd_pkg.sv =====
// ----------------------------------------------------------------------------
// nvcd_pkg
// Shared types, codes and constants of the nearest valid cell distance block.
// ----------------------------------------------------------------------------
package nvcd_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int COORD_IN_W = 8;
    localparam int GRID_W     = 9;
    localparam int DIST_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 24;
    localparam int POS_W      = 11;

    localparam int LATLON_NUM = 1117;
    localparam int LATLON_DEN = 10;
    localparam int LATLON_RND = 5;
    localparam int MUL_W      = 11;
    localparam int PROD_W     = DIST_W + MUL_W;

    // Division by ten: the dividend is split at RCP_SPLIT, and the low term
    // stays below 2^RCP_LOW_W, where the reciprocal below is exact.
    localparam int     RCP_SPLIT  = 16;
    localparam int     RCP_HI_MUL = (1 << RCP_SPLIT) / LATLON_DEN;
    localparam int     RCP_LO_MUL = (1 << RCP_SPLIT) % LATLON_DEN;
    localparam int     RCP_LOW_W  = 30;
    localparam int     RCP_SHIFT  = 33;
    localparam longint RCP_MUL    = ((longint'(1) << RCP_SHIFT) + LATLON_DEN - 1)
                                  / LATLON_DEN;

    localparam logic [GRID_W-1:0] RST_GRID_WIDTH   = 9'd256;
    localparam logic [GRID_W-1:0] RST_GRID_HEIGHT  = 9'd256;
    localparam logic [DIST_W-1:0] RST_CELL_SPACING = 32'd65536;
    localparam logic              RST_LATLON_MODE  = 1'b0;
    localparam logic [DIST_W-1:0] RST_MAX_RADIUS   = 32'd655360;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH   = 3'd0,
        CFG_GRID_HEIGHT  = 3'd1,
        CFG_CELL_SPACING = 3'd2,
        CFG_LATLON_MODE  = 3'd3,
        CFG_MAX_RADIUS   = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_CENTRE_CHK,
        ST_MUL,
        ST_DIV,
        ST_RING_INIT,
        ST_RING_CHK,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_RING,
        RES_MISS
    } t_res_sel;

    typedef struct packed {
        logic     load_wr;
        logic     latch;
        logic     rd_centre;
        logic     div_start;
        logic     ring_init;
        logic     walk_start;
        logic     walk;
        logic     next_ring;
        logic     res_load;
        t_res_sel res_sel;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic hit;
        logic grid_empty;
        logic latlon;
        logic div_done;
        logic ring_over;
        logic ring_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/nearest_valid_cell_distance.sv =====
// ----------------------------------------------------------------------------
// nearest_valid_cell_distance
// Distance from a grid cell to the nearest cell flagged as holding valid data.
// ----------------------------------------------------------------------------
// A load transaction writes one presence flag. A query transaction ends after
// the centre read when the named cell is itself valid; otherwise square rings
// of radius 1, 2 and upward are walked through the presence memory at one read
// per cycle, and in latitude-longitude mode the step distance is first formed
// by a divide by ten through reciprocal multiplication. The presence memory is
// not cleared at reset, so every cell inside the grid in use must be loaded
// before a query can reach it. The result register lets a new transaction be
// taken while a result waits.
// ----------------------------------------------------------------------------
module nearest_valid_cell_distance #(
    parameter int MAX_WIDTH  = nvcd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nvcd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // column [7:0], row [15:8], cell_present [16], zero [23:17]
    input  logic [nvcd_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // kind [0]
    input  logic [0:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // distance [31:0]
    output logic [nvcd_pkg::DIST_W-1:0]     o_m_axis_tdata,
    // not_found [0]
    output logic [0:0]                      o_m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nvcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nvcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    nvcd_pkg::t_cmd cmd;
    nvcd_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    nvcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nvcd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_kind   (i_s_axis_tuser[0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_dist  (o_m_axis_tdata),
        .o_out_nf    (o_m_axis_tuser[0])
    );

endmodule

// ===== rtl/nvcd_ram.sv =====
// ----------------------------------------------------------------------------
// nvcd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module nvcd_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/nvcd_div10.sv =====
// ----------------------------------------------------------------------------
// nvcd_div10
// Divider by ten using reciprocal multiplication.
// The dividend is split into a high and a low part; the high part is scaled by
// the integer quotient of 2^16 by ten, and the small remainder term is divided
// exactly by a multiplication with a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module nvcd_div10 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nvcd_pkg::PROD_W-1:0] i_dividend,
    output logic                        o_done,
    output logic [nvcd_pkg::PROD_W-1:0] o_quotient
);

    localparam int PW = nvcd_pkg::PROD_W;
    localparam int SW = nvcd_pkg::RCP_SPLIT;
    localparam int AW = PW - SW;
    localparam int CW = nvcd_pkg::RCP_LOW_W;

    logic            r_v1;
    logic            r_v2;
    logic            r_done;
    logic [AW-1:0]   r_a;
    logic [SW-1:0]   r_b;
    logic [PW-1:0]   r_hi;
    logic [CW-1:0]   r_c;
    logic [PW-1:0]   r_q;
    logic [2*CW-1:0] n_lo;

    always_comb begin
        n_lo = (2*CW)'(r_c) * (2*CW)'(nvcd_pkg::RCP_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_dividend[PW-1:SW];
            r_b <= i_dividend[SW-1:0];
        end
        if (r_v1) begin
            r_hi <= PW'(r_a) * PW'(nvcd_pkg::RCP_HI_MUL);
            r_c  <= CW'(r_a) * CW'(nvcd_pkg::RCP_LO_MUL) + CW'(r_b);
        end
        if (r_v2) begin
            r_q <= r_hi + PW'(n_lo[2*CW-1:nvcd_pkg::RCP_SHIFT]);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/nvcd_datapath.sv =====
// ----------------------------------------------------------------------------
// nvcd_datapath
// Configuration registers, presence memory, ring walker and result registers.
// ----------------------------------------------------------------------------
module nvcd_datapath #(
    parameter int MAX_WIDTH  = nvcd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nvcd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nvcd_pkg::t_cmd                  i_cmd,
    output nvcd_pkg::t_sts                  o_sts,
    input  logic [nvcd_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic                            i_in_kind,
    input  logic                            i_cfg_valid,
    input  logic [nvcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nvcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nvcd_pkg::DIST_W-1:0]     o_out_dist,
    output logic                            o_out_nf
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = nvcd_pkg::COORD_IN_W;
    localparam int GW     = nvcd_pkg::GRID_W;
    localparam int DW     = nvcd_pkg::DIST_W;
    localparam int PW     = nvcd_pkg::POS_W;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
        f_addr = ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    function automatic logic [GW-1:0] f_abs(input nvcd_pkg::t_pos v);
        nvcd_pkg::t_pos m;
        m = v[PW-1] ? -v : v;
        f_abs = m[GW-1:0];
    endfunction

    function automatic logic [GW-1:0] f_max(input logic [GW-1:0] a, input logic [GW-1:0] b);
        f_max = (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic [GW-1:0] r_grid_width;
    logic [GW-1:0] r_grid_height;
    logic [DW-1:0] r_cell_spacing;
    logic          r_latlon_mode;
    logic [DW-1:0] r_max_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= nvcd_pkg::RST_GRID_WIDTH;
            r_grid_height  <= nvcd_pkg::RST_GRID_HEIGHT;
            r_cell_spacing <= nvcd_pkg::RST_CELL_SPACING;
            r_latlon_mode  <= nvcd_pkg::RST_LATLON_MODE;
            r_max_radius   <= nvcd_pkg::RST_MAX_RADIUS;
        end else if (i_cfg_valid) begin
            case (nvcd_pkg::t_cfg_index'(i_cfg_index))
                nvcd_pkg::CFG_GRID_WIDTH:   r_grid_width   <= i_cfg_data[GW-1:0];
                nvcd_pkg::CFG_GRID_HEIGHT:  r_grid_height  <= i_cfg_data[GW-1:0];
                nvcd_pkg::CFG_CELL_SPACING: r_cell_spacing <= i_cfg_data[DW-1:0];
                nvcd_pkg::CFG_LATLON_MODE:  r_latlon_mode  <= i_cfg_data[0];
                nvcd_pkg::CFG_MAX_RADIUS:   r_max_radius   <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    logic [GW-1:0] w_eff;
    logic [GW-1:0] h_eff;

    always_comb begin
        w_eff = (int'(r_grid_width) < MAX_WIDTH) ? r_grid_width : GW'(MAX_WIDTH);
        h_eff = (int'(r_grid_height) < MAX_HEIGHT) ? r_grid_height : GW'(MAX_HEIGHT);
    end

    // Input fields.
    logic [CW-1:0] in_col;
    logic [CW-1:0] in_row;
    logic          in_present;

    assign in_col     = i_in_data[CW-1:0];
    assign in_row     = i_in_data[2*CW-1:CW];
    assign in_present = i_in_data[2*CW];

    // Query registers.
    logic [CW-1:0]  r_col;
    logic [CW-1:0]  r_row;
    logic [GW-1:0]  r_rlim;
    logic [GW-1:0]  r_radius;
    logic [DW-1:0]  r_step;
    logic [DW-1:0]  r_dist;
    nvcd_pkg::t_pos r_x;
    nvcd_pkg::t_pos r_y;
    logic [1:0]     r_side;
    logic [GW:0]    r_cnt;
    logic           r_pend;

    nvcd_pkg::t_pos cx;
    nvcd_pkg::t_pos cy;
    nvcd_pkg::t_pos rad;
    logic [GW-1:0]  n_rlim;
    logic           centre_in;
    logic           walk_in;
    logic [GW:0]    side_last;
    logic [DW:0]    dist_sum;
    logic [DW-1:0]  n_step;

    // Divider for the latitude-longitude step.
    logic [nvcd_pkg::PROD_W-1:0] prod;
    logic [nvcd_pkg::PROD_W-1:0] quot;
    logic                        div_done;

    assign prod = nvcd_pkg::PROD_W'(r_cell_spacing) * nvcd_pkg::PROD_W'(nvcd_pkg::LATLON_NUM)
                + nvcd_pkg::PROD_W'(nvcd_pkg::LATLON_RND);

    nvcd_div10 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    always_comb begin
        cx  = nvcd_pkg::t_pos'({3'b000, r_col});
        cy  = nvcd_pkg::t_pos'({3'b000, r_row});
        rad = nvcd_pkg::t_pos'({2'b00, r_radius});
        n_rlim = f_max(f_max(GW'(r_col), f_abs($signed({2'b00, w_eff}) - 11'sd1 - cx)),
                       f_max(GW'(r_row), f_abs($signed({2'b00, h_eff}) - 11'sd1 - cy)));
        centre_in = (GW'(r_col) < w_eff) && (GW'(r_row) < h_eff);
        walk_in   = !r_x[PW-1] && !r_y[PW-1]
                  && (r_x < $signed({2'b00, w_eff})) && (r_y < $signed({2'b00, h_eff}));
        side_last = {r_radius, 1'b0} - (GW+1)'(1);
        dist_sum  = {1'b0, r_dist} + {1'b0, r_step};
        if (r_latlon_mode) begin
            n_step = (quot[nvcd_pkg::PROD_W-1:DW] != '0) ? '1 : quot[DW-1:0];
        end else begin
            n_step = r_cell_spacing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_col <= in_col;
            r_row <= in_row;
        end
        if (i_cmd.rd_centre) begin
            r_rlim <= n_rlim;
        end
        if (i_cmd.ring_init) begin
            r_radius <= GW'(1);
            r_step   <= n_step;
            r_dist   <= n_step;
        end else if (i_cmd.next_ring) begin
            r_radius <= r_radius + 1'b1;
            r_dist   <= dist_sum[DW] ? '1 : dist_sum[DW-1:0];
        end
        if (i_cmd.walk_start) begin
            r_x    <= cx - rad;
            r_y    <= cy - rad;
            r_side <= 2'd0;
            r_cnt  <= '0;
        end else if (i_cmd.walk) begin
            if (r_cnt == side_last) begin
                r_side <= r_side + 1'b1;
                r_cnt  <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            case (r_side)
                2'd0:    r_x <= r_x + 11'sd1;
                2'd1:    r_y <= r_y + 11'sd1;
                2'd2:    r_x <= r_x - 11'sd1;
                default: r_y <= r_y - 11'sd1;
            endcase
        end
    end

    // Presence memory.
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_q;

    always_comb begin
        mem_we    = i_cmd.load_wr && (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
        mem_re    = (i_cmd.rd_centre && centre_in) || (i_cmd.walk && walk_in);
        mem_raddr = i_cmd.rd_centre ? f_addr(r_col, r_row) : f_addr(r_x[CW-1:0], r_y[CW-1:0]);
    end

    nvcd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_presence (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (f_addr(in_col, in_row)),
        .i_wdata (in_present),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= mem_re;
        end
    end

    // Result and output registers.
    logic [DW-1:0] r_res_dist;
    logic          r_res_nf;
    logic          r_out_valid;
    logic [DW-1:0] r_out_dist;
    logic          r_out_nf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                nvcd_pkg::RES_ZERO: begin
                    r_res_dist <= '0;
                    r_res_nf   <= 1'b0;
                end
                nvcd_pkg::RES_RING: begin
                    r_res_dist <= r_dist;
                    r_res_nf   <= 1'b0;
                end
                default: begin
                    r_res_dist <= r_max_radius;
                    r_res_nf   <= 1'b1;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_out_dist <= r_res_dist;
            r_out_nf   <= r_res_nf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_dist  = r_out_dist;
    assign o_out_nf    = r_out_nf;

    always_comb begin
        o_sts.in_query   = (i_in_kind == nvcd_pkg::KIND_QUERY);
        o_sts.hit        = r_pend && mem_q;
        o_sts.grid_empty = (w_eff == '0) || (h_eff == '0);
        o_sts.latlon     = r_latlon_mode;
        o_sts.div_done   = div_done;
        o_sts.ring_over  = (r_radius > r_rlim) || (r_dist >= r_max_radius);
        o_sts.ring_last  = (r_side == 2'd3) && (r_cnt == side_last);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

// ===== rtl/nvcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvcd_ctrl
// Sequencer for loads and ring-search queries.
// ----------------------------------------------------------------------------
module nvcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nvcd_pkg::t_sts i_sts,
    output nvcd_pkg::t_cmd o_cmd
);

    nvcd_pkg::t_state r_state;
    nvcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nvcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nvcd_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.in_query) begin
                    n_state = nvcd_pkg::ST_CENTRE;
                end
            end
            nvcd_pkg::ST_CENTRE: n_state = nvcd_pkg::ST_CENTRE_CHK;
            nvcd_pkg::ST_CENTRE_CHK: begin
                if (i_sts.hit || i_sts.grid_empty) begin
                    n_state = nvcd_pkg::ST_DONE;
                end else if (i_sts.latlon) begin
                    n_state = nvcd_pkg::ST_MUL;
                end else begin
                    n_state = nvcd_pkg::ST_RING_INIT;
                end
            end
            nvcd_pkg::ST_MUL: n_state = nvcd_pkg::ST_DIV;
            nvcd_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = nvcd_pkg::ST_RING_INIT;
                end
            end
            nvcd_pkg::ST_RING_INIT: n_state = nvcd_pkg::ST_RING_CHK;
            nvcd_pkg::ST_RING_CHK: begin
                n_state = i_sts.ring_over ? nvcd_pkg::ST_DONE : nvcd_pkg::ST_WALK;
            end
            nvcd_pkg::ST_WALK: begin
                if (i_sts.hit) begin
                    n_state = nvcd_pkg::ST_DONE;
                end else if (i_sts.ring_last) begin
                    n_state = nvcd_pkg::ST_DRAIN;
                end
            end
            nvcd_pkg::ST_DRAIN: begin
                n_state = i_sts.hit ? nvcd_pkg::ST_DONE : nvcd_pkg::ST_RING_CHK;
            end
            nvcd_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = nvcd_pkg::ST_IDLE;
                end
            end
            default: n_state = nvcd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.res_sel = nvcd_pkg::RES_MISS;
        o_in_ready    = 1'b0;
        case (r_state)
            nvcd_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_wr = i_in_valid && !i_sts.in_query;
                o_cmd.latch   = i_in_valid && i_sts.in_query;
            end
            nvcd_pkg::ST_CENTRE: o_cmd.rd_centre = 1'b1;
            nvcd_pkg::ST_CENTRE_CHK: begin
                o_cmd.res_load = i_sts.hit || i_sts.grid_empty;
                o_cmd.res_sel  = i_sts.hit ? nvcd_pkg::RES_ZERO : nvcd_pkg::RES_MISS;
            end
            nvcd_pkg::ST_MUL: o_cmd.div_start = 1'b1;
            nvcd_pkg::ST_DIV: ;
            nvcd_pkg::ST_RING_INIT: o_cmd.ring_init = 1'b1;
            nvcd_pkg::ST_RING_CHK: begin
                o_cmd.res_load   = i_sts.ring_over;
                o_cmd.walk_start = !i_sts.ring_over;
            end
            nvcd_pkg::ST_WALK: begin
                o_cmd.walk     = 1'b1;
                o_cmd.res_load = i_sts.hit;
                o_cmd.res_sel  = nvcd_pkg::RES_RING;
            end
            nvcd_pkg::ST_DRAIN: begin
                o_cmd.res_load  = i_sts.hit;
                o_cmd.res_sel   = nvcd_pkg::RES_RING;
                o_cmd.next_ring = !i_sts.hit;
            end
            nvcd_pkg::ST_DONE: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/nvcd_checker.sv =====
// ----------------------------------------------------------------------------
// nvcd_checker
// Port-level checks of the nearest valid cell distance block.
// ----------------------------------------------------------------------------
module nvcd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [nvcd_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input logic [0:0]                      i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [nvcd_pkg::DIST_W-1:0]     o_m_axis_tdata,
    input logic [0:0]                      o_m_axis_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [nvcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [nvcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic in_load;
    logic in_query;

    assign in_load  = i_s_axis_tvalid && o_s_axis_tready
                   && (i_s_axis_tuser[0] == nvcd_pkg::KIND_LOAD);
    assign in_query = i_s_axis_tvalid && o_s_axis_tready
                   && (i_s_axis_tuser[0] == nvcd_pkg::KIND_QUERY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("Result changed while stalled.");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load |=> o_s_axis_tready)
        else $error("Load transaction did not complete in one cycle.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_query |=> !o_s_axis_tready)
        else $error("Input taken while a query is in progress.");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("Result appeared without a query in progress.");

endmodule

bind nearest_valid_cell_distance nvcd_checker u_checker (.*);
